/* hdl/idal_pkg.sv */
`default_nettype none

package idal_pkg;

  localparam int ID_BITS     = 32;
  localparam int STACK_DEPTH = 64;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int PORT_ID_W = 32;
  localparam int STATUS_W  = 3;
  localparam int FREE_W    = 7;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RECYCLE = 1'b1;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [ID_BITS:0]   fresh_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FRESH     = 3'd0,
    ST_REUSED    = 3'd1,
    ST_RECYCLED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  // stack memory request for the cycle
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    id_t   wdata;
  } stk_req_t;

  // port-width id in, id masked to ID_BITS
  function automatic id_t port_to_id(logic [PORT_ID_W-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[ID_BITS-1:0];
  endfunction

  function automatic logic [PORT_ID_W-1:0] id_to_port(id_t x);
    logic [63:0] w;
    w = 64'(x);
    return w[PORT_ID_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/idal_ram.sv */
`default_nettype none

module idal_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/idal_ctrl.sv */
`default_nettype none

module idal_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            mode,
  input  wire logic [idal_pkg::PORT_ID_W-1:0]  returned_id,
  input  wire logic                            cfg_wr_en,
  input  wire logic [idal_pkg::PORT_ID_W-1:0]  cfg_wr_data,
  output logic                                 busy,
  output idal_pkg::stk_req_t                   stk_req,
  output logic                                 done,
  output idal_pkg::status_t                    status_q,
  output idal_pkg::id_t                        id_q,
  output idal_pkg::cnt_t                       count
);

  localparam idal_pkg::cnt_t DEPTH_CNT = idal_pkg::CNT_W'(idal_pkg::STACK_DEPTH);

  idal_pkg::fresh_t  fresh_counter;
  idal_pkg::fresh_t  fresh_counter_next;
  idal_pkg::cnt_t    count_next;
  idal_pkg::status_t status_next;
  idal_pkg::id_t     id_next;
  logic              accept;
  logic              stack_full;
  logic              stack_empty;
  logic              exhausted;

  assign accept      = start && !busy;
  assign stack_full  = (count == DEPTH_CNT);
  assign stack_empty = (count == '0);
  assign exhausted   = fresh_counter[idal_pkg::ID_BITS];

  always_comb begin
    fresh_counter_next = fresh_counter;
    count_next         = count;
    status_next        = idal_pkg::ST_FRESH;
    id_next            = '0;
    stk_req.we         = 1'b0;
    stk_req.re         = 1'b0;
    stk_req.addr       = count[idal_pkg::ADDR_W-1:0];
    stk_req.wdata      = idal_pkg::port_to_id(returned_id);
    if (accept) begin
      if (mode == idal_pkg::MODE_RECYCLE) begin
        if (stack_full) begin
          status_next = idal_pkg::ST_FULL;
        end else begin
          stk_req.we  = 1'b1;
          count_next  = count + 1'b1;
          status_next = idal_pkg::ST_RECYCLED;
        end
      end else if (!stack_empty) begin
        // pop: top entry lands in the RAM output register next cycle
        count_next   = count - 1'b1;
        stk_req.re   = 1'b1;
        stk_req.addr = count_next[idal_pkg::ADDR_W-1:0];
        status_next  = idal_pkg::ST_REUSED;
      end else if (exhausted) begin
        status_next = idal_pkg::ST_EXHAUSTED;
      end else begin
        id_next            = fresh_counter[idal_pkg::ID_BITS-1:0];
        fresh_counter_next = fresh_counter + 1'b1;
        status_next        = idal_pkg::ST_FRESH;
      end
    end
    if (cfg_wr_en) begin
      fresh_counter_next = {1'b0, idal_pkg::port_to_id(cfg_wr_data)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b1;
      done          <= 1'b0;
      count         <= '0;
      fresh_counter <= '0;
    end else begin
      busy          <= 1'b0;
      done          <= accept;
      count         <= count_next;
      fresh_counter <= fresh_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    id_q     <= id_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("stack count beyond depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted beat without result");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == idal_pkg::MODE_RECYCLE && !stack_full)
      |=> count == idal_pkg::CNT_W'($past(count) + 1'b1))
    else $error("push did not grow the stack");

  a_fresh_hold: assert property (@(posedge clk) disable iff (rst)
    (!cfg_wr_en && !(accept && mode == idal_pkg::MODE_ALLOC && stack_empty && !exhausted))
      |=> $stable(fresh_counter))
    else $error("fresh counter moved without a fresh grant");

endmodule

`default_nettype wire

/* hdl/id_allocator_with_recycle_stack_unit.sv */
`default_nettype none

// Id allocator with a LIFO stack of recycled ids.
// Request: pulse start with mode (0 allocate, 1 recycle) and returned_id; the
// beat is taken at a clock edge where start is high and busy is low. busy is
// only high during reset and up to the first clock edge after it, so a
// request can be taken every cycle.
// Result: done is high for one cycle, in the cycle after the request edge, with
// granted_id, status and free_entries. Throughput is one beat per cycle; a
// reused id comes from the registered read port of the stack memory.
// The receiver cannot stall; each result must be taken in its done cycle.
// Allocation pops the most recently recycled id, else hands out the fresh
// counter. A push onto a full stack is dropped (status 3); with an empty stack
// and the counter past the top id, allocation fails (status 4).
// cfg_wr_en / cfg_wr_data reload the fresh counter; write only while idle.
// Reset clears the stack count and loads the fresh counter with zero. Stack
// entries are not cleared; only entries below the count are ever read.
module id_allocator_with_recycle_stack_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   mode,
  input  wire logic [idal_pkg::PORT_ID_W-1:0]         returned_id,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [idal_pkg::PORT_ID_W-1:0]         cfg_wr_data,
  output logic                                        done,
  output logic      [idal_pkg::PORT_ID_W-1:0]         granted_id,
  output logic      [idal_pkg::STATUS_W-1:0]          status,
  output logic      [idal_pkg::FREE_W-1:0]            free_entries
);

  idal_pkg::stk_req_t stk_req;
  idal_pkg::status_t  status_q;
  idal_pkg::id_t      id_q;
  idal_pkg::id_t      stk_rdata;
  idal_pkg::cnt_t     count;

  idal_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .returned_id (returned_id),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .busy        (busy),
    .stk_req     (stk_req),
    .done        (done),
    .status_q    (status_q),
    .id_q        (id_q),
    .count       (count)
  );

  idal_ram #(
    .DEPTH  (idal_pkg::STACK_DEPTH),
    .WIDTH  (idal_pkg::ID_BITS),
    .ADDR_W (idal_pkg::ADDR_W)
  ) u_stack (
    .clk   (clk),
    .we    (stk_req.we),
    .re    (stk_req.re),
    .addr  (stk_req.addr),
    .wdata (stk_req.wdata),
    .rdata (stk_rdata)
  );

  // count register already holds the post-request value in the done cycle
  assign granted_id   = idal_pkg::id_to_port((status_q == idal_pkg::ST_REUSED) ? stk_rdata : id_q);
  assign status       = status_q;
  assign free_entries = idal_pkg::FREE_W'(count);

endmodule

`default_nettype wire

/* verif/tb_id_allocator_with_recycle_stack_unit.sv */
`timescale 1ns / 100ps

module tb_id_allocator_with_recycle_stack_unit;
  import idal_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [PORT_ID_W-1:0] id;
    status_t              st;
    logic [FREE_W-1:0]    free;
  } grant_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   mode = MODE_ALLOC;
  logic [PORT_ID_W-1:0]   returned_id = '0;
  logic                   cfg_wr_en = 1'b0;
  logic [PORT_ID_W-1:0]   cfg_wr_data = '0;
  logic                   busy;
  logic                   done;
  logic [PORT_ID_W-1:0]   granted_id;
  logic [STATUS_W-1:0]    status;
  logic [FREE_W-1:0]      free_entries;

  // allocator image: fresh counter, LIFO of recycled ids, entries held
  fresh_t                 next_fresh = '0;
  logic [FREE_W-1:0]      held = '0;
  id_t                    lifo [STACK_DEPTH];

  grant_t                 pending_grants [$];
  int                     err_cnt = 0;
  int                     beats_sent = 0;
  int                     id_loads = 0;
  int                     st_seen [5] = '{default: 0};
  int                     gap_max = 15;
  int                     cycle_cnt = 0;

  id_allocator_with_recycle_stack_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .returned_id  (returned_id),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .done         (done),
    .granted_id   (granted_id),
    .status       (status),
    .free_entries (free_entries)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_grants.size());
      $display("tb_id_allocator_with_recycle_stack_unit: done, errors");
      $finish;
    end
  end

  function automatic id_t port_id(logic [PORT_ID_W-1:0] x);
    return x[ID_BITS-1:0];
  endfunction

  function automatic grant_t grant_for(logic m, logic [PORT_ID_W-1:0] rid);
    grant_t g;
    g.id = '0;
    if (m == MODE_RECYCLE) begin
      if (held >= STACK_DEPTH) begin
        g.st = ST_FULL;
      end else begin
        lifo[held[ADDR_W-1:0]] = port_id(rid);
        held = held + 1'b1;
        g.st = ST_RECYCLED;
      end
    end else if (held != 0) begin
      held = held - 1'b1;
      g.id = lifo[held[ADDR_W-1:0]];
      g.st = ST_REUSED;
    end else if (next_fresh[ID_BITS]) begin
      g.st = ST_EXHAUSTED;
    end else begin
      g.id = next_fresh[ID_BITS-1:0];
      next_fresh = next_fresh + 1'b1;
      g.st = ST_FRESH;
    end
    g.free = held;
    return g;
  endfunction

  // one request beat; gap drawn up front so start is assigned once per step
  task automatic send_req(logic m, logic [PORT_ID_W-1:0] rid);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    returned_id <= rid;
    do @(posedge clk); while (busy);
    pending_grants.push_back(grant_for(m, rid));
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic load_first_id(logic [PORT_ID_W-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    next_fresh = {1'b0, port_id(v)};
    id_loads++;
  endtask

  function automatic logic [PORT_ID_W-1:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, PORT_ID_W - 1);
      3:       return ~(32'h1 << $urandom_range(0, PORT_ID_W - 1));
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst && done === 1'b1) begin
      if (pending_grants.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result id %h status %0d free %0d",
                 $time, granted_id, status, free_entries);
      end else begin
        exp_g = pending_grants.pop_front();
        if (int'(exp_g.st) < 5) st_seen[int'(exp_g.st)]++;
        if (granted_id !== exp_g.id) begin
          err_cnt++;
          $display("%0t: granted_id expected %h actual %h", $time, exp_g.id, granted_id);
        end
        if (status !== exp_g.st) begin
          err_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, exp_g.st, status);
        end
        if (free_entries !== exp_g.free) begin
          err_cnt++;
          $display("%0t: free_entries expected %0d actual %0d",
                   $time, exp_g.free, free_entries);
        end
      end
    end
  end

  // fresh ids from zero, LIFO reuse order, field extremes
  task automatic test_basic_grants();
    gap_max = 2;
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'hFFFF_FFFF);
    send_req(MODE_RECYCLE, 32'hFFFF_FFFF);
    send_req(MODE_RECYCLE, 32'h0000_0000);
    send_req(MODE_RECYCLE, 32'hA5A5_A5A5);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_RECYCLE, 32'h5A5A_5A5A);
    send_req(MODE_ALLOC, 32'h1234_5678);
  endtask

  // counter at the top of the id space; register write reloads it
  task automatic test_exhaustion();
    gap_max = 0;
    while (held != 0) send_req(MODE_ALLOC, pick_id());
    load_first_id(32'hFFFF_FFFE);
    repeat (4) send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_RECYCLE, 32'h1234_5678);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    load_first_id(32'hFFFF_FFFF);
    send_req(MODE_ALLOC, 32'h0);
    send_req(MODE_ALLOC, 32'h0);
    load_first_id(32'h0000_0000);
    send_req(MODE_ALLOC, 32'h0);
  endtask

  // fill the stack, push past full, then pop everything back
  task automatic test_stack_limits();
    gap_max = 15;
    while (held < STACK_DEPTH) begin
      if ($urandom_range(0, 3) == 0) gap_max = 0;
      else gap_max = 15;
      send_req(MODE_RECYCLE, pick_id());
    end
    repeat (3) send_req(MODE_RECYCLE, pick_id());
    gap_max = 0;
    while (held != 0) send_req(MODE_ALLOC, pick_id());
    send_req(MODE_ALLOC, pick_id());
  endtask

  // segments biased toward push or pop so the stack swings full and empty
  task automatic test_random_traffic(int n_beats);
    int left;
    int seg;
    int push_pct;
    left = n_beats;
    while (left > 0) begin
      seg = $urandom_range(10, 80);
      if (seg > left) seg = left;
      case ($urandom_range(0, 2))
        0:       push_pct = 90;
        1:       push_pct = 10;
        default: push_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 15;
      endcase
      repeat (seg) begin
        if ($urandom_range(0, 99) < push_pct) send_req(MODE_RECYCLE, pick_id());
        else send_req(MODE_ALLOC, pick_id());
      end
      left -= seg;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_basic_grants();
    test_exhaustion();
    test_stack_limits();
    test_random_traffic(250);
    load_first_id($urandom);
    test_random_traffic(250);
    load_first_id(32'hFFFF_FFC0);
    test_random_traffic(250);
    load_first_id(32'h8000_0000);
    test_random_traffic(250);
    drain_results();
    repeat (4) @(posedge clk);
    $display("%0d request beats over %0d counter loads", beats_sent, id_loads);
    $display("fresh %0d, reused %0d, recycled %0d, dropped full %0d, exhausted %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    if (err_cnt == 0 && pending_grants.size() == 0) begin
      $display("tb_id_allocator_with_recycle_stack_unit: done, clean");
    end else begin
      $display("tb_id_allocator_with_recycle_stack_unit: done, errors");
    end
    $finish;
  end

endmodule
